>>> rtl/rde_pkg.sv
// Shared constants for the ring deque engine: field widths, operation and status codes.
package rde_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_REAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_REAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_DISPLAY   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

>>> rtl/rde_if.sv
// Valid/ready channel interfaces for the ring deque engine request and result streams.
interface rde_in_if;
  logic                               valid;
  logic                               ready;
  logic        [rde_pkg::OP_W-1:0]    operation;
  logic signed [rde_pkg::VALUE_W-1:0] item_value;

  modport source (output valid, output operation, output item_value, input ready);
  modport sink   (input valid, input operation, input item_value, output ready);
endinterface

interface rde_out_if;
  logic                                valid;
  logic                                ready;
  logic        [rde_pkg::STATUS_W-1:0] status;
  logic signed [rde_pkg::VALUE_W-1:0]  data_value;
  logic                                last_of_run;

  modport source (output valid, output status, output data_value, output last_of_run,
                  input ready);
  modport sink   (input valid, input status, input data_value, input last_of_run,
                  output ready);
endinterface

>>> rtl/rde_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
module rde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/ring_deque_engine.sv
// Ring deque engine: bounded double-ended queue of signed 32-bit items held in one RAM.
//
// Requests arrive on in_ch (valid/ready), one operation per transfer: insert front,
// insert rear, delete front, delete rear or display. Results leave on out_ch from an
// output register; last_of_run marks the final result of each request. Codes 5 to 7
// are dropped without a result.
// Inserts write the RAM in the cycle of the transfer and the result is registered at once
// when the output register is free (else it waits in S_HOLD), so inserts and status-only
// results can run back to back. Deletes read the RAM through its registered read port and
// load the value into the output register from S_READ. Display walks the ring from a
// first RAM read issued at the transfer, one entry per cycle while results are taken.
// One request is in flight at a time; in_ch.ready is high only when idle, so RAM
// accesses never overlap and no forwarding is needed.
// A stalled receiver holds the output register and freezes the walk or the pending
// result until the transfer happens; nothing is dropped.
// Reset clears front pointer, count and the control state; RAM contents are not cleared
// and are read only after being written.
module ring_deque_engine #(
  parameter int DEPTH = rde_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rde_in_if.sink      in_ch,
  rde_out_if.source   out_ch
);

  import rde_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(2 * DEPTH);

  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HOLD,
    S_READ,
    S_WALK
  } state_t;

  // (base + off) mod DEPTH, with off <= DEPTH
  function automatic logic [AW-1:0] pos_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  state_t                state_r, state_nxt;
  logic [AW-1:0]         front_r, front_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [STATUS_W-1:0]   pend_status_r, pend_status_nxt;
  logic [AW-1:0]         walk_pos_r, walk_pos_nxt;
  logic [CW-1:0]         walk_left_r, walk_left_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]    out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  acc;
  logic                  out_free;
  logic                  single;
  logic [STATUS_W-1:0]   res_status;
  logic [AW-1:0]         front_m1;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_W-1:0]    ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_W-1:0]    ram_rdata;

  rde_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign acc                = in_ch.valid && in_ch.ready;
  assign out_free           = !out_valid_r || out_ch.ready;
  assign front_m1           = (front_r == '0) ? LAST_POS : front_r - AW'(1);
  assign ram_wdata          = in_ch.item_value;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.data_value  = out_data_r;
  assign out_ch.last_of_run = out_last_r;

  always_comb begin
    state_nxt       = state_r;
    front_nxt       = front_r;
    count_nxt       = count_r;
    pend_status_nxt = pend_status_r;
    walk_pos_nxt    = walk_pos_r;
    walk_left_nxt   = walk_left_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_data_nxt    = out_data_r;
    out_last_nxt    = out_last_r;
    single          = 1'b0;
    res_status      = ST_OK;
    ram_we          = 1'b0;
    ram_waddr       = front_r;
    ram_re          = 1'b0;
    ram_raddr       = front_r;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (in_ch.operation)
            OP_INS_FRONT: begin
              single = 1'b1;
              if (count_r == FULL_CNT) begin
                res_status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_m1;
                front_nxt = front_m1;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_INS_REAR: begin
              single = 1'b1;
              if (count_r == FULL_CNT) begin
                res_status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pos_add(front_r, count_r);
                count_nxt = count_r + CW'(1);
              end
            end
            OP_DEL_FRONT: begin
              if (count_r == '0) begin
                single     = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = front_r;
                front_nxt = pos_add(front_r, CW'(1));
                count_nxt = count_r - CW'(1);
                state_nxt = S_READ;
              end
            end
            OP_DEL_REAR: begin
              if (count_r == '0) begin
                single     = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = pos_add(front_r, count_r - CW'(1));
                count_nxt = count_r - CW'(1);
                state_nxt = S_READ;
              end
            end
            OP_DISPLAY: begin
              if (count_r == '0) begin
                single     = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                ram_re        = 1'b1;
                ram_raddr     = front_r;
                walk_pos_nxt  = pos_add(front_r, CW'(1));
                walk_left_nxt = count_r;
                state_nxt     = S_WALK;
              end
            end
            default: ;
          endcase

          // status-only results go straight out if the register is free
          if (single) begin
            if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = res_status;
              out_data_nxt   = '0;
              out_last_nxt   = 1'b1;
            end else begin
              pend_status_nxt = res_status;
              state_nxt       = S_HOLD;
            end
          end
        end
      end

      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_data_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_READ: begin
        // read data stays put until the next read, so a stall just waits
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = ram_rdata;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_WALK: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = ram_rdata;
          out_last_nxt   = (walk_left_r == CW'(1));
          if (walk_left_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re        = 1'b1;
            ram_raddr     = walk_pos_r;
            walk_pos_nxt  = pos_add(walk_pos_r, CW'(1));
            walk_left_nxt = walk_left_r - CW'(1);
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_status_r <= pend_status_nxt;
    walk_pos_r    <= walk_pos_nxt;
    walk_left_r   <= walk_left_nxt;
    out_status_r  <= out_status_nxt;
    out_data_r    <= out_data_nxt;
    out_last_r    <= out_last_nxt;
  end

endmodule
